>>> sv/spm_pkg.sv
// package of shared types and constants for the sparse polynomial multiplier
package spm_pkg;

    localparam int MAX_TERMS   = 8;
    localparam int IDX_W       = $clog2(MAX_TERMS);
    localparam int CNT_W       = $clog2(MAX_TERMS + 1);
    localparam int COEF_W      = 16;
    localparam int EXPON_W     = 8;
    localparam int PCOEF_W     = 36;
    localparam int PEXPON_W    = 9;
    localparam int TBL_DEPTH   = 1 << PEXPON_W;
    localparam int MUL_W       = 2 * COEF_W;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_MUL    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COEF_W-1:0]  term_coef;
        logic [EXPON_W-1:0]        term_expon;
    } t_in_word;

    typedef struct packed {
        logic signed [PCOEF_W-1:0] prod_coef;
        logic [PEXPON_W-1:0]       prod_expon;
        logic                      last;
        logic                      empty_res;
    } t_out_word;

    typedef struct packed {
        logic                      used;
        logic signed [PCOEF_W-1:0] coef;
    } t_entry;

endpackage

>>> sv/sparse_polynomial_multiply.sv
// sparse polynomial multiplier: term stores, exponent-indexed accumulator table, sequencer
// sequence: a load word is stored from the idle state; a multiply word reads and then writes
// back the table entry for each term pair (one multiplier and one 36-bit adder shared over all
// pairs), then sweeps the 512-entry accumulator table from the top exponent down, holding on output stalls
// throughput: one word in flight; the input stalls until the last result word is queued
// reset: synchronous active low, then a pass over all 512 entries clears the table before any input word
module sparse_polynomial_multiply
    import spm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EMPTY  = 7'b0000100,
        ST_MUL_RD = 7'b0001000,
        ST_MUL_WR = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_FLUSH  = 7'b1000000
    } t_state;

    localparam logic [PEXPON_W-1:0] TOP_ADDR = PEXPON_W'(TBL_DEPTH - 1);

    t_state r_state;

    // operand stores
    logic signed [COEF_W-1:0] r_a_coef [MAX_TERMS];
    logic [EXPON_W-1:0]       r_a_exp  [MAX_TERMS];
    logic signed [COEF_W-1:0] r_b_coef [MAX_TERMS];
    logic [EXPON_W-1:0]       r_b_exp  [MAX_TERMS];
    logic [CNT_W-1:0]         r_a_cnt;
    logic [CNT_W-1:0]         r_b_cnt;
    logic [IDX_W-1:0]         r_i;
    logic [IDX_W-1:0]         r_j;

    // accumulator table, one entry per exponent
    t_entry r_tbl [TBL_DEPTH];
    t_entry r_rdata;
    logic                mem_re;
    logic [PEXPON_W-1:0] mem_ra;
    logic                mem_we;
    logic [PEXPON_W-1:0] mem_wa;
    t_entry              mem_wd;

    // shared multiply and accumulate
    logic signed [MUL_W-1:0]   mul;
    logic [PEXPON_W-1:0]       sum_exp;
    logic signed [PCOEF_W-1:0] r_prod;
    logic [PEXPON_W-1:0]       r_waddr;

    // sweep control
    logic [PEXPON_W-1:0] r_addr;
    logic                r_more;
    logic                r_sv;
    logic [PEXPON_W-1:0] r_sexp;
    logic                r_hold_v;
    t_out_word           r_hold;
    logic                advance;

    // output register
    logic      r_out_v;
    t_out_word r_out;
    logic      out_free;
    logic      out_load;

    logic in_acc;
    logic a_last;
    logic b_last;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;
    assign out_free    = !r_out_v || !i_out_stall;

    assign mul     = r_a_coef[r_i] * r_b_coef[r_j];
    assign sum_exp = PEXPON_W'(r_a_exp[r_i]) + PEXPON_W'(r_b_exp[r_j]);
    assign a_last  = (CNT_W'(r_i) + CNT_W'(1)) == r_a_cnt;
    assign b_last  = (CNT_W'(r_j) + CNT_W'(1)) == r_b_cnt;

    // the sweep may move on unless a found term must displace the held one into a busy output
    assign advance = !(r_sv && r_rdata.used && r_hold_v && !out_free);

    // a new word enters the output register this cycle
    assign out_load = ((r_state == ST_EMPTY) && out_free) ||
                      ((r_state == ST_SCAN) && advance && r_sv && r_rdata.used && r_hold_v) ||
                      ((r_state == ST_FLUSH) && out_free);

    always_comb begin
        mem_re = 1'b0;
        mem_ra = r_addr;
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_MUL_RD: begin
                mem_re = 1'b1;
                mem_ra = sum_exp;
            end
            ST_MUL_WR: begin
                mem_we      = 1'b1;
                mem_wa      = r_waddr;
                mem_wd.used = 1'b1;
                mem_wd.coef = r_rdata.used ? (r_rdata.coef + r_prod) : r_prod;
            end
            ST_SCAN: begin
                // read each entry and clear it behind the read
                mem_re = advance && r_more;
                mem_we = advance && r_more;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tbl[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_tbl[mem_ra];
        end
    end

    // operand stores take a word while below capacity
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_word.op == OP_LOAD_A && r_a_cnt < CNT_W'(MAX_TERMS)) begin
            r_a_coef[r_a_cnt[IDX_W-1:0]] <= i_in_word.term_coef;
            r_a_exp[r_a_cnt[IDX_W-1:0]]  <= i_in_word.term_expon;
        end
        if (in_acc && i_in_word.op == OP_LOAD_B && r_b_cnt < CNT_W'(MAX_TERMS)) begin
            r_b_coef[r_b_cnt[IDX_W-1:0]] <= i_in_word.term_coef;
            r_b_exp[r_b_cnt[IDX_W-1:0]]  <= i_in_word.term_expon;
        end
        if (r_state == ST_MUL_RD) begin
            r_prod  <= PCOEF_W'(mul);
            r_waddr <= sum_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_a_cnt  <= '0;
            r_b_cnt  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_more   <= 1'b0;
            r_sv     <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + PEXPON_W'(1);
                    if (r_addr == TOP_ADDR) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        priority if (i_in_word.op == OP_LOAD_A) begin
                            if (r_a_cnt < CNT_W'(MAX_TERMS)) begin
                                r_a_cnt <= r_a_cnt + CNT_W'(1);
                            end
                        end else if (i_in_word.op == OP_LOAD_B) begin
                            if (r_b_cnt < CNT_W'(MAX_TERMS)) begin
                                r_b_cnt <= r_b_cnt + CNT_W'(1);
                            end
                        end else if (i_in_word.op == OP_MUL) begin
                            r_i <= '0;
                            r_j <= '0;
                            if (r_a_cnt == '0 || r_b_cnt == '0) begin
                                r_a_cnt <= '0;
                                r_b_cnt <= '0;
                                r_state <= ST_EMPTY;
                            end else begin
                                r_state <= ST_MUL_RD;
                            end
                        end else begin
                        end
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        r_out.prod_coef   <= '0;
                        r_out.prod_expon  <= '0;
                        r_out.last        <= 1'b1;
                        r_out.empty_res   <= 1'b1;
                        r_state           <= ST_IDLE;
                    end
                end
                ST_MUL_RD: begin
                    r_state <= ST_MUL_WR;
                end
                ST_MUL_WR: begin
                    // walk the pairs row by row
                    r_state <= ST_MUL_RD;
                    if (b_last) begin
                        r_j <= '0;
                        if (a_last) begin
                            r_a_cnt <= '0;
                            r_b_cnt <= '0;
                            r_addr  <= TOP_ADDR;
                            r_more  <= 1'b1;
                            r_sv    <= 1'b0;
                            r_state <= ST_SCAN;
                        end else begin
                            r_i <= r_i + IDX_W'(1);
                        end
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                ST_SCAN: begin
                    if (advance) begin
                        if (r_sv && r_rdata.used) begin
                            if (r_hold_v) begin
                                r_out <= r_hold;
                            end
                            r_hold_v          <= 1'b1;
                            r_hold.prod_coef  <= r_rdata.coef;
                            r_hold.prod_expon <= r_sexp;
                            r_hold.last       <= 1'b0;
                            r_hold.empty_res  <= 1'b0;
                        end
                        if (r_more) begin
                            r_sv   <= 1'b1;
                            r_sexp <= r_addr;
                            if (r_addr == '0) begin
                                r_more <= 1'b0;
                            end else begin
                                r_addr <= r_addr - PEXPON_W'(1);
                            end
                        end else begin
                            r_sv <= 1'b0;
                            if (!r_sv) begin
                                r_state <= ST_FLUSH;
                            end
                        end
                    end
                end
                ST_FLUSH: begin
                    // held term is the lowest exponent, so it closes the product
                    if (out_free) begin
                        r_out        <= '{prod_coef: r_hold.prod_coef,
                                          prod_expon: r_hold.prod_expon,
                                          last: 1'b1,
                                          empty_res: r_hold.empty_res};
                        r_hold_v     <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
